// ===== rtl/sbdg_pkg.sv =====
// Package for the steered beamforming delay generator.
// Holds grid and scale constants, register codes, sideband type and window table.
// No dependencies.
`default_nettype none

package sbdg_pkg;

    // geometry in units of 2^-30 m
    localparam int PITCH_U     = 327277;
    localparam int PIXEL_U     = 214748;
    localparam int SAMPLE_U    = 20670;
    localparam int STEP_CENTER = 30;
    localparam int DELAY_SCALE = 26597403;
    localparam int DELAY_MAX   = 16777215;

    localparam int MAX_HALF_APERTURE = 32;
    localparam int WINDOW_SLOTS      = 65;

    // centre element: divide by twice the pitch through a reciprocal
    localparam longint CEN_DIV   = 2 * PITCH_U;
    localparam int     CEN_K     = 38;
    localparam longint CEN_RECIP = (64'd1 << CEN_K) / CEN_DIV;

    // aperture half-size: divide 5*r by 14 pitches
    localparam longint HALF_DIV   = 14 * PITCH_U;
    localparam int     HALF_K     = 29;
    localparam longint HALF_RECIP = (64'd1 << HALF_K) / HALF_DIV;
    localparam longint HALF_LIM   = (MAX_HALF_APERTURE + 1) * HALF_DIV;

    typedef enum logic [2:0] {
        CFG_TIME_OFFSET = 3'd0,
        CFG_SIN_ANGLE   = 3'd1,
        CFG_COS_ANGLE   = 3'd2,
        CFG_TAN_ANGLE   = 3'd3,
        CFG_SEC_ANGLE   = 3'd4,
        CFG_X_START     = 3'd5,
        CFG_Z_START     = 3'd6
    } t_cfg_idx;

    // fields that ride alongside the distance and root pipeline
    typedef struct packed {
        logic [5:0]         half;
        logic [15:0]        elem;
        logic [15:0]        weight;
        logic               slot_ok;
        logic signed [35:0] z;
        logic [3:0]         shift;
    } t_side;

    // Hamming weight for the rising half of the window, Q1.15
    function automatic logic [15:0] half_window(input logic [5:0] idx);
        logic [15:0] w;
        case (idx)
            6'd0:  w = 16'd2621;
            6'd1:  w = 16'd2694;
            6'd2:  w = 16'd2911;
            6'd3:  w = 16'd3270;
            6'd4:  w = 16'd3769;
            6'd5:  w = 16'd4401;
            6'd6:  w = 16'd5162;
            6'd7:  w = 16'd6043;
            6'd8:  w = 16'd7036;
            6'd9:  w = 16'd8132;
            6'd10: w = 16'd9320;
            6'd11: w = 16'd10589;
            6'd12: w = 16'd11926;
            6'd13: w = 16'd13319;
            6'd14: w = 16'd14754;
            6'd15: w = 16'd16217;
            6'd16: w = 16'd17695;
            6'd17: w = 16'd19172;
            6'd18: w = 16'd20635;
            6'd19: w = 16'd22070;
            6'd20: w = 16'd23463;
            6'd21: w = 16'd24800;
            6'd22: w = 16'd26069;
            6'd23: w = 16'd27257;
            6'd24: w = 16'd28353;
            6'd25: w = 16'd29347;
            6'd26: w = 16'd30228;
            6'd27: w = 16'd30988;
            6'd28: w = 16'd31621;
            6'd29: w = 16'd32119;
            6'd30: w = 16'd32478;
            6'd31: w = 16'd32695;
            6'd32: w = 16'd32768;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/steered_beamform_delay_generator_unit.sv =====
// Top level of the steered beamforming delay generator: config registers,
// pipeline chain and output skid stage. Uses sbdg_pkg and the sbdg_* modules.
//
//  channel   dir  handshake              payload
//  s stream  in   i_s_tvalid/o_s_tready  i_s_tdata  column, row, step, slot
//  m stream  out  o_m_tvalid/i_m_tready  o_m_tdata  half, element, weight, delay
//                                        o_m_tuser  slot_valid, delay_clipped
//  config    in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// One word per clock in and out when not stalled; stages: 7 geometry, 5 distance,
// 32 square-root (one per root bit), 4 delay, and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stalled output parks one word in the skid stage; o_s_tready drops only
// while that stage is full, and the whole pipeline then holds.
`default_nettype none

module steered_beamform_delay_generator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [39:0]  i_s_tdata,  // column_index, row_index, sample_step, aperture_slot
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [63:0] o_m_tdata,  // aperture_half, element_index, window_weight, delay_samples
    output logic [1:0]  o_m_tuser,  // slot_valid, delay_clipped
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [31:0]  i_cfg_data
);

    logic signed [23:0] r_toff;
    logic signed [18:0] r_sin, r_cos, r_tan, r_sec;
    logic signed [31:0] r_x_start, r_z_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toff    <= '0;
            r_sin     <= '0;
            r_cos     <= 19'sd65536;
            r_tan     <= '0;
            r_sec     <= 19'sd65536;
            r_x_start <= '0;
            r_z_start <= '0;
        end else if (i_cfg_we) begin
            case (sbdg_pkg::t_cfg_idx'(i_cfg_idx))
                sbdg_pkg::CFG_TIME_OFFSET: r_toff    <= $signed(i_cfg_data[23:0]);
                sbdg_pkg::CFG_SIN_ANGLE:   r_sin     <= $signed(i_cfg_data[18:0]);
                sbdg_pkg::CFG_COS_ANGLE:   r_cos     <= $signed(i_cfg_data[18:0]);
                sbdg_pkg::CFG_TAN_ANGLE:   r_tan     <= $signed(i_cfg_data[18:0]);
                sbdg_pkg::CFG_SEC_ANGLE:   r_sec     <= $signed(i_cfg_data[18:0]);
                sbdg_pkg::CFG_X_START:     r_x_start <= $signed(i_cfg_data);
                sbdg_pkg::CFG_Z_START:     r_z_start <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    logic r_sk_vld;
    logic r_out_vld;
    logic w_en;

    assign w_en       = !r_sk_vld;
    assign o_s_tready = w_en;

    logic               w_g_vld;
    logic signed [21:0] w_g_elem;
    logic signed [35:0] w_g_x;
    sbdg_pkg::t_side    w_g_side;

    sbdg_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (i_s_tvalid && w_en),
        .i_col     (i_s_tdata[9:0]),
        .i_row     (i_s_tdata[19:10]),
        .i_step    (i_s_tdata[25:20]),
        .i_slot    (i_s_tdata[32:26]),
        .i_sin     (r_sin),
        .i_cos     (r_cos),
        .i_tan     (r_tan),
        .i_sec     (r_sec),
        .i_x_start (r_x_start),
        .i_z_start (r_z_start),
        .o_vld     (w_g_vld),
        .o_elem    (w_g_elem),
        .o_x       (w_g_x),
        .o_side    (w_g_side)
    );

    logic               w_d_vld;
    logic [62:0]        w_d_n;
    sbdg_pkg::t_side    w_d_side;

    sbdg_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_g_vld),
        .i_elem  (w_g_elem),
        .i_x     (w_g_x),
        .i_side  (w_g_side),
        .o_vld   (w_d_vld),
        .o_n     (w_d_n),
        .o_side  (w_d_side)
    );

    logic               w_q_vld;
    logic [31:0]        w_q_root;
    sbdg_pkg::t_side    w_q_side;

    sbdg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_n     (w_d_n),
        .i_side  (w_d_side),
        .o_vld   (w_q_vld),
        .o_root  (w_q_root),
        .o_side  (w_q_side)
    );

    logic               w_p_vld;
    logic [23:0]        w_p_delay;
    logic               w_p_clip;
    sbdg_pkg::t_side    w_p_side;

    sbdg_delay u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_q_vld),
        .i_root  (w_q_root),
        .i_side  (w_q_side),
        .i_toff  (r_toff),
        .o_vld   (w_p_vld),
        .o_delay (w_p_delay),
        .o_clip  (w_p_clip),
        .o_side  (w_p_side)
    );

    logic [63:0] w_p_data;
    logic [1:0]  w_p_user;
    logic [63:0] r_out_data, r_sk_data;
    logic [1:0]  r_out_user, r_sk_user;

    assign w_p_data = {2'b00, w_p_delay, w_p_side.weight, w_p_side.elem, w_p_side.half};
    assign w_p_user = {w_p_clip, w_p_side.slot_ok};

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (!r_out_vld || i_m_tready) begin
            r_out_vld <= r_sk_vld || w_p_vld;
            r_sk_vld  <= 1'b0;
        end else if (w_p_vld && !r_sk_vld) begin
            r_sk_vld  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_tready) begin
            r_out_data <= r_sk_vld ? r_sk_data : w_p_data;
            r_out_user <= r_sk_vld ? r_sk_user : w_p_user;
        end else if (!r_sk_vld) begin
            r_sk_data <= w_p_data;
            r_sk_user <= w_p_user;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |->
        (o_m_tdata[61:38] == 24'd0 || o_m_tdata[61:38] == 24'hFFFFFF))
        else $error("clipped delay not at a bound");

    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[5:0] >= 6'd4
                        && o_m_tdata[5:0] <= 6'(sbdg_pkg::MAX_HALF_APERTURE)))
        else $error("aperture half-size out of range");

    a_weight_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[37:22] == 16'd0))
        else $error("weight on a slot outside the aperture");

endmodule

`default_nettype wire

// ===== rtl/sbdg_geom.sv =====
// Pixel geometry stages: position, centre element, aperture half-size,
// element index, slot check and window weight. Uses sbdg_pkg.
`default_nettype none

module sbdg_geom (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire [9:0]           i_col,
    input  wire [9:0]           i_row,
    input  wire [5:0]           i_step,
    input  wire [6:0]           i_slot,
    input  wire signed [18:0]   i_sin,
    input  wire signed [18:0]   i_cos,
    input  wire signed [18:0]   i_tan,
    input  wire signed [18:0]   i_sec,
    input  wire signed [31:0]   i_x_start,
    input  wire signed [31:0]   i_z_start,
    output logic                o_vld,
    output logic signed [21:0]  o_elem,
    output logic signed [35:0]  o_x,
    output sbdg_pkg::t_side     o_side
);

    logic [6:0] r_v;

    // stage 1: pixel position and step offset
    logic [27:0]        w_colp, w_rowp;
    logic signed [6:0]  w_stp;
    logic signed [33:0] n1_xc, n1_zc;
    logic signed [20:0] n1_off;
    logic signed [33:0] r1_xc, r1_zc;
    logic signed [20:0] r1_off;
    logic [6:0]         r1_slot;

    assign w_colp = 28'(i_col) * 28'(sbdg_pkg::PIXEL_U);
    assign w_rowp = 28'(i_row) * 28'(sbdg_pkg::PIXEL_U);
    assign w_stp  = $signed({1'b0, i_step}) - 7'(sbdg_pkg::STEP_CENTER);
    assign n1_xc  = 34'(i_x_start) + 34'($signed({1'b0, w_colp}));
    assign n1_zc  = 34'(i_z_start) + 34'($signed({1'b0, w_rowp}));
    assign n1_off = 21'(w_stp) * 21'(sbdg_pkg::SAMPLE_U);

    // stage 2: products with the steering trig values
    logic signed [52:0] r2_zt, r2_zs;
    logic signed [39:0] r2_os, r2_oc;
    logic signed [33:0] r2_xc, r2_zc;
    logic [6:0]         r2_slot;

    // stage 3: dividends and steered position
    logic signed [52:0] w_zt_sh, w_zs_sh;
    logic signed [39:0] w_os_sh, w_oc_sh;
    logic signed [37:0] w_num, w_t, w_r;
    logic [37:0]        n3_a, n3_v5;
    logic               n3_neg, n3_rpos;
    logic [37:0]        r3_a, r3_v5;
    logic               r3_neg, r3_rpos;
    logic signed [35:0] r3_x, r3_z;
    logic [6:0]         r3_slot;

    assign w_zt_sh = r2_zt >>> 16;
    assign w_zs_sh = r2_zs >>> 16;
    assign w_os_sh = r2_os >>> 16;
    assign w_oc_sh = r2_oc >>> 16;
    assign w_num   = 38'(r2_xc) - 38'(w_zt_sh);
    assign w_t     = (w_num <<< 1) + 38'(sbdg_pkg::PITCH_U);
    assign n3_neg  = w_t[37];
    assign n3_a    = n3_neg ? 38'(-w_t) : 38'(w_t);
    assign w_r     = 38'(w_zs_sh);
    assign n3_rpos = !w_r[37] && (w_r != 38'sd0);
    assign n3_v5   = 38'(w_r * 38'sd5);

    // stage 4: reciprocal estimates
    logic [57:0] w_pc;
    logic [35:0] w_ph;
    logic [19:0] r4_qc;
    logic [6:0]  r4_qh;
    logic        r4_big;
    logic [37:0] r4_a;
    logic [28:0] r4_vv;
    logic        r4_neg, r4_rpos;
    logic signed [35:0] r4_x, r4_z;
    logic [6:0]  r4_slot;

    assign w_pc = 58'(r3_a) * 58'(sbdg_pkg::CEN_RECIP);
    assign w_ph = 36'(r3_v5[28:0]) * 36'(sbdg_pkg::HALF_RECIP);

    // stage 5: back-multiply for the one-step correction
    logic [39:0] r5_pc;
    logic [29:0] r5_ph;
    logic [19:0] r5_qc;
    logic [6:0]  r5_qh;
    logic        r5_big;
    logic [37:0] r5_a;
    logic [28:0] r5_vv;
    logic        r5_neg, r5_rpos;
    logic signed [35:0] r5_x, r5_z;
    logic [6:0]  r5_slot;

    // stage 6: corrected quotients, centre and clamped half-size
    logic [19:0]        w_qc;
    logic [6:0]         w_qh;
    logic signed [20:0] w_cq;
    logic signed [20:0] n6_centre;
    logic [6:0]         n6_half;
    logic signed [20:0] r6_centre;
    logic [6:0]         r6_half;
    logic signed [35:0] r6_x, r6_z;
    logic [6:0]         r6_slot;

    assign w_qc = r5_qc + 20'((40'(r5_a) - r5_pc) >= 40'(sbdg_pkg::CEN_DIV));
    assign w_qh = r5_qh + 7'((30'(r5_vv) - r5_ph) >= 30'(sbdg_pkg::HALF_DIV));
    assign w_cq = $signed({1'b0, w_qc});
    assign n6_centre = r5_neg ? -w_cq : w_cq;

    always_comb begin
        if (!r5_rpos) begin
            n6_half = 7'd4;
        end else if (r5_big || (w_qh > 7'(sbdg_pkg::MAX_HALF_APERTURE))) begin
            n6_half = 7'(sbdg_pkg::MAX_HALF_APERTURE);
        end else if (w_qh < 7'd4) begin
            n6_half = 7'd4;
        end else begin
            n6_half = w_qh;
        end
    end

    // stage 7: element, slot check, window weight
    logic signed [21:0] n7_elem;
    logic               n7_ok;
    logic [5:0]         w_widx;
    logic [15:0]        n7_weight;

    assign n7_elem = 22'(r6_centre) + 22'($signed({1'b0, r6_slot}))
                     - 22'($signed({1'b0, r6_half}));
    assign n7_ok   = {1'b0, r6_slot} <= {r6_half, 1'b0};
    assign w_widx  = (r6_slot <= 7'd32) ? r6_slot[5:0] : 6'(7'd64 - r6_slot);
    assign n7_weight = (n7_ok && (r6_slot <= 7'd64)
                        && (8'(r6_slot) < 8'(sbdg_pkg::WINDOW_SLOTS)))
                       ? sbdg_pkg::half_window(w_widx) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_xc   <= n1_xc;
            r1_zc   <= n1_zc;
            r1_off  <= n1_off;
            r1_slot <= i_slot;

            r2_zt   <= 53'(r1_zc) * 53'(i_tan);
            r2_zs   <= 53'(r1_zc) * 53'(i_sec);
            r2_os   <= 40'(r1_off) * 40'(i_sin);
            r2_oc   <= 40'(r1_off) * 40'(i_cos);
            r2_xc   <= r1_xc;
            r2_zc   <= r1_zc;
            r2_slot <= r1_slot;

            r3_a    <= n3_a;
            r3_neg  <= n3_neg;
            r3_v5   <= n3_v5;
            r3_rpos <= n3_rpos;
            r3_x    <= 36'(r2_xc) + 36'(w_os_sh);
            r3_z    <= 36'(r2_zc) + 36'(w_oc_sh);
            r3_slot <= r2_slot;

            r4_qc   <= w_pc[57:38];
            r4_qh   <= w_ph[35:29];
            r4_big  <= r3_v5 >= 38'(sbdg_pkg::HALF_LIM);
            r4_a    <= r3_a;
            r4_vv   <= r3_v5[28:0];
            r4_neg  <= r3_neg;
            r4_rpos <= r3_rpos;
            r4_x    <= r3_x;
            r4_z    <= r3_z;
            r4_slot <= r3_slot;

            r5_pc   <= 40'(r4_qc) * 40'(sbdg_pkg::CEN_DIV);
            r5_ph   <= 30'(r4_qh) * 30'(sbdg_pkg::HALF_DIV);
            r5_qc   <= r4_qc;
            r5_qh   <= r4_qh;
            r5_big  <= r4_big;
            r5_a    <= r4_a;
            r5_vv   <= r4_vv;
            r5_neg  <= r4_neg;
            r5_rpos <= r4_rpos;
            r5_x    <= r4_x;
            r5_z    <= r4_z;
            r5_slot <= r4_slot;

            r6_centre <= n6_centre;
            r6_half   <= n6_half;
            r6_x      <= r5_x;
            r6_z      <= r5_z;
            r6_slot   <= r5_slot;

            o_elem         <= n7_elem;
            o_x            <= r6_x;
            o_side.half    <= r6_half[5:0];
            o_side.elem    <= n7_elem[15:0];
            o_side.weight  <= n7_weight;
            o_side.slot_ok <= n7_ok;
            o_side.z       <= r6_z;
            o_side.shift   <= 4'd0;
        end
    end

    assign o_vld = r_v[6];

endmodule

`default_nettype wire

// ===== rtl/sbdg_dist.sv =====
// Distance stages: element position, offsets, range normalization and
// sum of squares feeding the root pipeline. Uses sbdg_pkg.
`default_nettype none

module sbdg_dist (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire signed [21:0]   i_elem,
    input  wire signed [35:0]   i_x,
    input  sbdg_pkg::t_side     i_side,
    output logic                o_vld,
    output logic [62:0]         o_n,
    output sbdg_pkg::t_side     o_side
);

    logic [4:0] r_v;

    logic signed [41:0] r1_ep;
    logic signed [35:0] r1_x;
    sbdg_pkg::t_side    r1_side;

    logic signed [41:0] w_dx;
    logic [40:0]        r2_a;
    logic [35:0]        r2_b;
    sbdg_pkg::t_side    r2_side;

    logic [40:0]        w_m;
    logic [40:0]        w_bx;
    logic [3:0]         n3_s;
    sbdg_pkg::t_side    n3_side;
    logic [30:0]        r3_as, r3_bs;
    sbdg_pkg::t_side    r3_side;

    logic [61:0]        r4_aa, r4_bb;
    sbdg_pkg::t_side    r4_side;

    assign w_dx = 42'(r1_x) - r1_ep;
    assign w_bx = 41'(r2_b);
    assign w_m  = r2_a | w_bx;

    // smallest shift that brings both magnitudes below 2^31
    always_comb begin
        n3_s = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if ((w_m >> (31 + k)) != 41'd0) begin
                n3_s = 4'(k + 1);
            end
        end
    end

    // carry the shift with the word so the root can be scaled back
    always_comb begin
        n3_side       = r2_side;
        n3_side.shift = n3_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ep   <= 42'(i_elem) * 42'(sbdg_pkg::PITCH_U);
            r1_x    <= i_x;
            r1_side <= i_side;

            r2_a    <= w_dx[41] ? 41'(-w_dx) : 41'(w_dx);
            r2_b    <= r1_side.z[35] ? 36'(-r1_side.z) : 36'(r1_side.z);
            r2_side <= r1_side;

            r3_as   <= 31'(r2_a >> n3_s);
            r3_bs   <= 31'(w_bx >> n3_s);
            r3_side <= n3_side;

            r4_aa   <= 62'(r3_as) * 62'(r3_as);
            r4_bb   <= 62'(r3_bs) * 62'(r3_bs);
            r4_side <= r3_side;

            o_n     <= 63'(r4_aa) + 63'(r4_bb);
            o_side  <= r4_side;
        end
    end

    assign o_vld = r_v[4];

endmodule

`default_nettype wire

// ===== rtl/sbdg_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, 32 stages.
// Carries the sideband of each word alongside. Uses sbdg_pkg.
`default_nettype none

module sbdg_isqrt (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire [62:0]          i_n,
    input  sbdg_pkg::t_side     i_side,
    output logic                o_vld,
    output logic [31:0]         o_root,
    output sbdg_pkg::t_side     o_side
);

    localparam int STAGES = 32;

    logic               r_v    [STAGES];
    logic [62:0]        r_n    [STAGES];
    logic [62:0]        r_res  [STAGES];
    sbdg_pkg::t_side    r_side [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stg
        localparam logic [62:0] BIT = 63'(1) << (62 - 2 * g);
        logic               w_vin;
        logic [62:0]        w_nin, w_rin, w_try;
        sbdg_pkg::t_side    w_sin;

        if (g == 0) begin : g_head
            assign w_vin = i_vld;
            assign w_nin = i_n;
            assign w_rin = '0;
            assign w_sin = i_side;
        end else begin : g_body
            assign w_vin = r_v[g-1];
            assign w_nin = r_n[g-1];
            assign w_rin = r_res[g-1];
            assign w_sin = r_side[g-1];
        end

        assign w_try = w_rin + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_sin;
                if (w_nin >= w_try) begin
                    r_n[g]   <= w_nin - w_try;
                    r_res[g] <= (w_rin >> 1) + BIT;
                end else begin
                    r_n[g]   <= w_nin;
                    r_res[g] <= w_rin >> 1;
                end
            end
        end
    end

    assign o_vld  = r_v[STAGES-1];
    assign o_root = r_res[STAGES-1][31:0];
    assign o_side = r_side[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/sbdg_delay.sv =====
// Delay stages: path length, scaling to Q17.7 samples with rounding,
// acquisition offset and saturation. Uses sbdg_pkg.
`default_nettype none

module sbdg_delay (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire [31:0]          i_root,
    input  sbdg_pkg::t_side     i_side,
    input  wire signed [23:0]   i_toff,
    output logic                o_vld,
    output logic [23:0]         o_delay,
    output logic                o_clip,
    output sbdg_pkg::t_side     o_side
);

    localparam logic signed [69:0] RND = 70'sh80000000;

    logic [3:0] r_v;

    logic [41:0]        w_hyp;
    logic signed [43:0] r1_path;
    sbdg_pkg::t_side    r1_side;

    logic signed [46:0] r2_hh;
    logic [46:0]        r2_ll;
    sbdg_pkg::t_side    r2_side;

    logic signed [69:0] w_sum;
    logic signed [37:0] r3_d0;
    sbdg_pkg::t_side    r3_side;

    logic signed [38:0] w_d;
    logic [23:0]        n4_delay;
    logic               n4_clip;

    assign w_hyp = 42'(i_root) << i_side.shift;

    // path split in two halves to keep each product narrow
    assign w_sum = (70'(r2_hh) <<< 22) + 70'($signed({1'b0, r2_ll})) + RND;
    assign w_d   = 39'(r3_d0) + 39'(i_toff);

    always_comb begin
        if (w_d < 39'sd0) begin
            n4_delay = 24'd0;
            n4_clip  = 1'b1;
        end else if (w_d > 39'(sbdg_pkg::DELAY_MAX)) begin
            n4_delay = 24'(sbdg_pkg::DELAY_MAX);
            n4_clip  = 1'b1;
        end else begin
            n4_delay = w_d[23:0];
            n4_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_path <= 44'(i_side.z) + 44'($signed({1'b0, w_hyp}));
            r1_side <= i_side;

            r2_hh   <= 47'($signed(r1_path[43:22])) * 47'(sbdg_pkg::DELAY_SCALE);
            r2_ll   <= 47'(r1_path[21:0]) * 47'(sbdg_pkg::DELAY_SCALE);
            r2_side <= r1_side;

            r3_d0   <= $signed(w_sum[69:32]);
            r3_side <= r2_side;

            o_delay <= n4_delay;
            o_clip  <= n4_clip;
            o_side  <= r3_side;
        end
    end

    assign o_vld = r_v[3];

endmodule

`default_nettype wire
